FILE: rtl/avm_pkg.sv
`timescale 1ns / 1ps

package avm_pkg;

    // sample averaging
    localparam int SAMPLE_COUNT   = 50;
    localparam int ADC_FULL_SCALE = 1024;
    localparam int ADC_W          = 10;
    localparam int SUM_W          = 16;
    localparam int CNT_W          = $clog2(SAMPLE_COUNT + 1);

    // exact sum / SAMPLE_COUNT as a multiply by reciprocal and shift
    localparam int AVG_SHIFT = 22;
    localparam int RECIP     = ((2 ** AVG_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int AVG_PROD_W = SUM_W + RECIP_W;

    // scaling to centivolts
    localparam int ADC_SHIFT = $clog2(ADC_FULL_SCALE);
    localparam int SCALE_W   = 13;
    localparam int THR_W     = 8;
    localparam int CV_W      = 12;
    localparam int CV_PROD_W = ADC_W + SCALE_W;
    localparam logic [CV_W-1:0] CV_MAX = {CV_W{1'b1}};

    // decimal split by reciprocal multiply
    localparam int DIV100_MULT   = 5243;
    localparam int DIV100_SHIFT  = 19;
    localparam int DIV100_MULT_W = 13;
    localparam int WHOLE_W       = 6;
    localparam int FRAC_W        = 7;
    localparam int DIV10_MULT    = 205;
    localparam int DIV10_SHIFT   = 11;
    localparam int DIV10_MULT_W  = 8;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 4;
    localparam int POS_W         = 2;
    localparam int SEG_W         = 7;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // batch pipeline depth in the back end
    localparam int BATCH_STAGES = 5;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CV = 2'd1;
    localparam logic [SCALE_W-1:0] SCALE_MULT_RESET   = 13'd2760;
    localparam logic [THR_W-1:0]   THRESHOLD_CV_RESET = 8'd5;

    typedef enum logic {
        KIND_BATCH,
        KIND_TICK
    } item_kind_t;

    typedef struct packed {
        item_kind_t       kind;
        logic [SUM_W-1:0] sum;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale_mult;
        logic [THR_W-1:0]   threshold_cv;
    } cfg_t;

    // seven segment code, bit0 = a .. bit6 = g
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/avm_front.sv
`timescale 1ns / 1ps

module avm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [avm_pkg::ADC_W-1:0]     adc_sample,
    input  logic                          q_full,
    output avm_pkg::q_push_t              q_push
);

    logic [avm_pkg::SUM_W-1:0] sum_reg;
    logic [avm_pkg::SUM_W-1:0] sum_next;
    logic [avm_pkg::CNT_W-1:0] count_reg;
    logic [avm_pkg::CNT_W-1:0] count_next;
    logic [avm_pkg::SUM_W-1:0] sum_add;
    logic [avm_pkg::CNT_W-1:0] count_inc;
    logic                      accept;
    logic                      batch_done;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // running sum and batch count
    assign sum_add    = sum_reg + avm_pkg::SUM_W'(adc_sample);
    assign count_inc  = count_reg + avm_pkg::CNT_W'(1);
    assign batch_done = (count_inc == avm_pkg::CNT_W'(avm_pkg::SAMPLE_COUNT));

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept && (cmd == avm_pkg::CMD_SAMPLE))
        begin
            if (batch_done)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_inc;
            end
        end
    end

    // classify: ticks always go on, samples only when a batch closes
    always_comb
    begin
        q_push.push       = accept && ((cmd == avm_pkg::CMD_TICK) || batch_done);
        q_push.entry.kind = (cmd == avm_pkg::CMD_TICK) ? avm_pkg::KIND_TICK
                                                       : avm_pkg::KIND_BATCH;
        q_push.entry.sum  = sum_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/avm_queue.sv
`timescale 1ns / 1ps

module avm_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  avm_pkg::q_push_t   q_push,
    input  logic               pop,
    output avm_pkg::q_entry_t  head,
    output logic               empty,
    output logic               full
);

    avm_pkg::q_entry_t            entries_reg [avm_pkg::Q_DEPTH];
    logic [avm_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [avm_pkg::Q_PTR_W-1:0]  wr_ptr_next;
    logic [avm_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [avm_pkg::Q_PTR_W-1:0]  rd_ptr_next;
    logic [avm_pkg::Q_CNT_W-1:0]  count_reg;
    logic [avm_pkg::Q_CNT_W-1:0]  count_next;
    logic                         do_push;
    logic                         do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == avm_pkg::Q_CNT_W'(avm_pkg::Q_DEPTH));
    assign do_push = q_push.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + avm_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + avm_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + avm_pkg::Q_CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - avm_pkg::Q_CNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/avm_back.sv
`timescale 1ns / 1ps

module avm_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  avm_pkg::cfg_t                  cfg,
    input  avm_pkg::q_entry_t              head,
    input  logic                           empty,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [avm_pkg::NUM_DIGITS-1:0] digit_select,
    output logic [avm_pkg::SEG_W-1:0]      segments,
    output logic                           dot_on
);

    logic [avm_pkg::BATCH_STAGES-1:0] stage_vld_reg;
    logic [avm_pkg::BATCH_STAGES-1:0] stage_vld_next;
    logic                             busy;
    logic                             out_free;
    logic                             pop_batch;
    logic                             pop_tick;

    logic [avm_pkg::SUM_W-1:0]        s1_sum_reg;
    logic [avm_pkg::AVG_PROD_W-1:0]   avg_prod;
    logic [avm_pkg::ADC_W-1:0]        s2_avg_reg;
    logic [avm_pkg::CV_PROD_W-1:0]    cv_prod;
    logic [avm_pkg::CV_PROD_W-1:0]    cv_shift;
    logic [avm_pkg::CV_W-1:0]         cv_sat;
    logic [avm_pkg::CV_W-1:0]         s3_cv_reg;
    logic [avm_pkg::CV_W-1:0]         cv_diff;
    logic                             cv_take;
    logic [avm_pkg::CV_W+avm_pkg::DIV100_MULT_W-1:0] whole_prod;
    logic [avm_pkg::CV_W-1:0]         s4_cv_reg;
    logic [avm_pkg::WHOLE_W-1:0]      s4_whole_reg;
    logic                             s4_take_reg;
    logic [avm_pkg::CV_W-1:0]         frac_full;
    logic [avm_pkg::WHOLE_W-1:0]      s5_whole_reg;
    logic [avm_pkg::FRAC_W-1:0]       s5_frac_reg;
    logic                             s5_take_reg;
    logic [avm_pkg::FRAC_W+avm_pkg::DIV10_MULT_W-1:0] tens_prod;
    logic [avm_pkg::FRAC_W+avm_pkg::DIV10_MULT_W-1:0] tenths_prod;
    logic [avm_pkg::DIGIT_W-1:0]      d0;
    logic [avm_pkg::DIGIT_W-1:0]      d1;
    logic [avm_pkg::DIGIT_W-1:0]      d2;
    logic [avm_pkg::DIGIT_W-1:0]      d3;

    logic [avm_pkg::CV_W-1:0]         last_cv_reg;
    logic [avm_pkg::CV_W-1:0]         last_cv_next;
    logic [avm_pkg::DIGIT_W-1:0]      shown_digits_reg [avm_pkg::NUM_DIGITS];
    logic [avm_pkg::POS_W-1:0]        scan_pos_reg;
    logic [avm_pkg::POS_W-1:0]        scan_pos_next;
    logic [avm_pkg::POS_W-1:0]        pos;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [avm_pkg::NUM_DIGITS-1:0]   digit_select_reg;
    logic [avm_pkg::SEG_W-1:0]        segments_reg;
    logic                             dot_on_reg;

    // issue: batches run one at a time, ticks wait for a batch to settle
    assign busy      = |stage_vld_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop_batch = !empty && (head.kind == avm_pkg::KIND_BATCH) && !busy;
    assign pop_tick  = !empty && (head.kind == avm_pkg::KIND_TICK) && !busy && out_free;
    assign pop       = pop_batch || pop_tick;

    assign stage_vld_next = {stage_vld_reg[avm_pkg::BATCH_STAGES-2:0], pop_batch};

    // stage 1: average by reciprocal multiply
    assign avg_prod = avm_pkg::AVG_PROD_W'(s1_sum_reg)
                    * avm_pkg::AVG_PROD_W'(avm_pkg::RECIP);

    // stage 2: scale to centivolts and saturate
    assign cv_prod  = avm_pkg::CV_PROD_W'(s2_avg_reg) * avm_pkg::CV_PROD_W'(cfg.scale_mult);
    assign cv_shift = cv_prod >> avm_pkg::ADC_SHIFT;
    assign cv_sat   = (|cv_shift[avm_pkg::CV_PROD_W-1:avm_pkg::CV_W]) ? avm_pkg::CV_MAX
                                                                   : cv_shift[avm_pkg::CV_W-1:0];

    // stage 3: change check against last reading, whole volts
    assign cv_diff    = (s3_cv_reg > last_cv_reg) ? s3_cv_reg - last_cv_reg
                                                  : last_cv_reg - s3_cv_reg;
    assign cv_take    = cv_diff > avm_pkg::CV_W'(cfg.threshold_cv);
    assign whole_prod = ($bits(whole_prod))'(s3_cv_reg)
                      * ($bits(whole_prod))'(avm_pkg::DIV100_MULT);

    always_comb
    begin
        last_cv_next = last_cv_reg;
        if (stage_vld_reg[2] && cv_take)
        begin
            last_cv_next = s3_cv_reg;
        end
    end

    // stage 4: centivolt remainder
    assign frac_full = s4_cv_reg - avm_pkg::CV_W'(s4_whole_reg) * avm_pkg::CV_W'(100);

    // stage 5: split into four digits
    assign tens_prod   = ($bits(tens_prod))'(s5_whole_reg)
                       * ($bits(tens_prod))'(avm_pkg::DIV10_MULT);
    assign tenths_prod = ($bits(tenths_prod))'(s5_frac_reg)
                       * ($bits(tenths_prod))'(avm_pkg::DIV10_MULT);
    assign d0 = tens_prod[avm_pkg::DIV10_SHIFT +: avm_pkg::DIGIT_W];
    assign d1 = avm_pkg::DIGIT_W'(avm_pkg::WHOLE_W'(s5_whole_reg)
              - avm_pkg::WHOLE_W'(d0) * avm_pkg::WHOLE_W'(10));
    assign d2 = tenths_prod[avm_pkg::DIV10_SHIFT +: avm_pkg::DIGIT_W];
    assign d3 = avm_pkg::DIGIT_W'(s5_frac_reg - avm_pkg::FRAC_W'(d2) * avm_pkg::FRAC_W'(10));

    // scan: skip the leading zero of the tens digit
    always_comb
    begin
        pos = scan_pos_reg;
        if ((scan_pos_reg == '0) && (shown_digits_reg[0] == '0))
        begin
            pos = avm_pkg::POS_W'(1);
        end
        scan_pos_next = pop_tick ? pos + avm_pkg::POS_W'(1) : scan_pos_reg;
    end

    assign out_valid_next = pop_tick || (out_valid_reg && out_stall);

    // batch datapath registers
    always_ff @(posedge clk)
    begin
        if (pop_batch)
        begin
            s1_sum_reg <= head.sum;
        end
        s2_avg_reg   <= avg_prod[avm_pkg::AVG_SHIFT +: avm_pkg::ADC_W];
        s3_cv_reg    <= cv_sat;
        s4_cv_reg    <= s3_cv_reg;
        s4_whole_reg <= whole_prod[avm_pkg::DIV100_SHIFT +: avm_pkg::WHOLE_W];
        s4_take_reg  <= cv_take;
        s5_whole_reg <= s4_whole_reg;
        s5_frac_reg  <= frac_full[avm_pkg::FRAC_W-1:0];
        s5_take_reg  <= s4_take_reg;
    end

    // output item register
    always_ff @(posedge clk)
    begin
        if (pop_tick)
        begin
            digit_select_reg <= avm_pkg::NUM_DIGITS'(1) << pos;
            segments_reg     <= avm_pkg::seg_of(shown_digits_reg[pos]);
            dot_on_reg       <= (pos == avm_pkg::POS_W'(1));
        end
    end

    // control and display state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= '0;
            out_valid_reg <= 1'b0;
            last_cv_reg   <= '0;
            scan_pos_reg  <= '0;
            for (int i = 0; i < avm_pkg::NUM_DIGITS; i++)
            begin
                shown_digits_reg[i] <= '0;
            end
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
            out_valid_reg <= out_valid_next;
            last_cv_reg   <= last_cv_next;
            scan_pos_reg  <= scan_pos_next;
            if (stage_vld_reg[4] && s5_take_reg)
            begin
                shown_digits_reg[0] <= d0;
                shown_digits_reg[1] <= d1;
                shown_digits_reg[2] <= d2;
                shown_digits_reg[3] <= d3;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_select = digit_select_reg;
    assign segments     = segments_reg;
    assign dot_on       = dot_on_reg;

endmodule

FILE: rtl/averaging_voltmeter_display.sv
// Scan tick: queued, then registered as the output item when nothing is queued ahead.
// Throughput: one item per cycle unless stalled; samples give no result, ticks one each.
// The sample that closes a batch holds the back end through issue, then average, scale,
// compare, remainder and split, while later ticks wait in the 4-entry queue.
// Reset clears sums, reading, digits and scan position; registers return to 2760 and 5.
`timescale 1ns / 1ps

module averaging_voltmeter_display
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [avm_pkg::ADC_W-1:0]          adc_sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [avm_pkg::NUM_DIGITS-1:0]     digit_select,
    output logic [avm_pkg::SEG_W-1:0]          segments,
    output logic                               dot_on,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [avm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [avm_pkg::SCALE_W-1:0]        cfg_data
);

    avm_pkg::cfg_t              cfg;
    logic [avm_pkg::SCALE_W-1:0] scale_mult_reg;
    logic [avm_pkg::SCALE_W-1:0] scale_mult_next;
    logic [avm_pkg::THR_W-1:0]   threshold_cv_reg;
    logic [avm_pkg::THR_W-1:0]   threshold_cv_next;
    avm_pkg::q_push_t           q_push;
    avm_pkg::q_entry_t          q_head;
    logic                       q_empty;
    logic                       q_full;
    logic                       q_pop;

    // configuration registers, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_comb
    begin
        scale_mult_next   = scale_mult_reg;
        threshold_cv_next = threshold_cv_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == avm_pkg::REG_SCALE_MULT)
            begin
                scale_mult_next = cfg_data;
            end
            else if (cfg_index == avm_pkg::REG_THRESHOLD_CV)
            begin
                threshold_cv_next = cfg_data[avm_pkg::THR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_mult_reg   <= avm_pkg::SCALE_MULT_RESET;
            threshold_cv_reg <= avm_pkg::THRESHOLD_CV_RESET;
        end
        else
        begin
            scale_mult_reg   <= scale_mult_next;
            threshold_cv_reg <= threshold_cv_next;
        end
    end

    assign cfg.scale_mult   = scale_mult_reg;
    assign cfg.threshold_cv = threshold_cv_reg;

    // front end: accumulate samples, classify items
    avm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .adc_sample (adc_sample),
        .q_full     (q_full),
        .q_push     (q_push)
    );

    // decoupling queue
    avm_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .head   (q_head),
        .empty  (q_empty),
        .full   (q_full)
    );

    // back end: reading update and display scan
    avm_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digit_select (digit_select),
        .segments     (segments),
        .dot_on       (dot_on)
    );

`ifndef SYNTH
    // exactly one digit driven per item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(digit_select))
        else $error("digit select not one-hot");

    // dot goes with the second digit only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dot_on == digit_select[1]))
        else $error("dot not tied to second digit");

    // stored digits are always decimal, so never blank
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (segments != '0))
        else $error("blank segment pattern");

    // front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push |-> !q_full)
        else $error("push into full queue");
`endif

endmodule
